### hw/rtl/nccsbm_pkg.sv
// ----------------------------------------------------------------------------
// nccsbm_pkg
// Shared types and constants of the NCC stereo block matcher.
// ----------------------------------------------------------------------------
package nccsbm_pkg;

  localparam int COL_W  = 12;
  localparam int ROW_W  = 12;
  localparam int SLOT_W = 4;
  localparam int DISP_W = 7;
  localparam int SUM_W  = 16;
  localparam int SQ_W   = 24;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_MIN_DISP  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_DISP  = 3'd1;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd3;
  localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd4;

  typedef struct packed {
    logic [7:0]               left_pixel;
    logic [7:0]               right_pixel;
    logic [COL_W-1:0]         col;
    logic [SLOT_W-1:0]        slot;
    logic                     search;
    logic signed [DISP_W-1:0] d_lo;
    logic signed [DISP_W-1:0] d_hi;
    logic                     frame_end;
  } job_t;

endpackage

### hw/rtl/nccsbm_front.sv
// ----------------------------------------------------------------------------
// nccsbm_front
// Holds the configuration registers and the raster counters, and turns each
// accepted pixel word into a job with its clipped disparity range.
// ----------------------------------------------------------------------------
module nccsbm_front #(
  parameter int WIN       = 4,
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_DISP  = 63
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [7:0]                         left_pixel,
  input  logic [7:0]                         right_pixel,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nccsbm_pkg::IDX_W-1:0]       cfg_index,
  input  logic [15:0]                        cfg_data,
  output logic                               job_valid,
  input  logic                               job_ready,
  output nccsbm_pkg::job_t                   job,
  output logic signed [15:0]                 threshold
);
  import nccsbm_pkg::*;

  localparam int ROWS = 2 * WIN + 1;

  logic signed [DISP_W-1:0] min_disp, max_disp;
  logic [10:0]              width_r;
  logic [12:0]              height_r;
  logic [COL_W-1:0]         col;
  logic [ROW_W-1:0]         row;
  logic [SLOT_W-1:0]        slot;

  logic [12:0]              w, h;
  logic [COL_W-1:0]         col_e;
  logic [ROW_W-1:0]         row_e;
  logic [SLOT_W-1:0]        slot_e;
  logic                     col_last, row_last, in_border, accept;
  logic signed [13:0]       lo_c, hi_c, lo_col, lo_eff;

  assign cfg_ready   = 1'b1;
  assign job_valid   = pixel_valid;
  assign pixel_ready = job_ready;
  assign accept      = pixel_valid && job_ready;

  always_comb begin
    w = (width_r == 11'd0) ? 13'd1 :
        ({2'b0, width_r} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {2'b0, width_r};
    h = (height_r == 13'd0) ? 13'd1 : (height_r > 13'd4096) ? 13'd4096 : height_r;
    col_e  = ({1'b0, col} >= w) ? '0 : col;
    row_e  = ({1'b0, row} >= h) ? '0 : row;
    slot_e = ({1'b0, row} >= h) ? '0 : slot;
    col_last = ({1'b0, col_e} + 13'd1) >= w;
    row_last = ({1'b0, row_e} + 13'd1) >= h;
    in_border = (col_e >= COL_W'(2 * WIN)) && (row_e >= ROW_W'(2 * WIN));
    lo_c = 14'(min_disp);
    hi_c = 14'(max_disp);
    if (lo_c < -14'sd0 - 14'(MAX_DISP)) lo_c = 14'sd0 - 14'(MAX_DISP);
    if (hi_c > 14'sd0) hi_c = 14'sd0;
    lo_col = 14'(2 * WIN) - $signed({2'b0, col_e});
    lo_eff = (lo_c > lo_col) ? lo_c : lo_col;
    job.left_pixel  = left_pixel;
    job.right_pixel = right_pixel;
    job.col         = col_e;
    job.slot        = slot_e;
    job.search      = in_border && (lo_eff <= hi_c);
    job.d_lo        = DISP_W'(lo_eff);
    job.d_hi        = DISP_W'(hi_c);
    job.frame_end   = col_last && row_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_disp  <= -7'sd30;
      max_disp  <= -7'sd7;
      threshold <= 16'sd31130;
      width_r   <= 11'd640;
      height_r  <= 13'd480;
      col       <= '0;
      row       <= '0;
      slot      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MIN_DISP:  min_disp  <= cfg_data[DISP_W-1:0];
          REG_MAX_DISP:  max_disp  <= cfg_data[DISP_W-1:0];
          REG_THRESHOLD: threshold <= cfg_data;
          REG_WIDTH:     width_r   <= cfg_data[10:0];
          REG_HEIGHT:    height_r  <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (col_last) begin
          col <= '0;
          if (row_last) begin
            row  <= '0;
            slot <= '0;
          end else begin
            row  <= row_e + ROW_W'(1);
            slot <= (slot_e == SLOT_W'(ROWS - 1)) ? '0 : slot_e + SLOT_W'(1);
          end
        end else begin
          col  <= col_e + COL_W'(1);
          row  <= row_e;
          slot <= slot_e;
        end
      end
    end
  end

endmodule

### hw/rtl/nccsbm_queue.sv
// ----------------------------------------------------------------------------
// nccsbm_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module nccsbm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  nccsbm_pkg::job_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output nccsbm_pkg::job_t pop_data
);
  import nccsbm_pkg::*;

  job_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/nccsbm_back.sv
// ----------------------------------------------------------------------------
// nccsbm_back
// Line stores and the scoring engine: window sums, zero-mean NCC through an
// iterative square root and divider, winner take all and the result register.
// ----------------------------------------------------------------------------
module nccsbm_back #(
  parameter int WIN       = 4,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     job_valid,
  output logic                                     job_ready,
  input  nccsbm_pkg::job_t                         job,
  input  logic signed [15:0]                       threshold,
  output logic                                     result_valid,
  input  logic                                     result_ready,
  output logic signed [nccsbm_pkg::DISP_W-1:0]     disparity,
  output logic signed [15:0]                       match_score,
  output logic                                     valid_res,
  output logic                                     frame_end
);
  import nccsbm_pkg::*;

  localparam int ROWS  = 2 * WIN + 1;
  localparam int NPIX  = ROWS * ROWS;
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SUMA, S_VAM, S_VAD, S_CORR, S_MUL, S_DIF, S_PROD,
    S_SQRT, S_DIVP, S_DIV, S_SCORE, S_NEXT, S_DONE
  } state_t;

  state_t                   state;
  logic [7:0]               lmem [DEPTH];
  logic [7:0]               rmem [DEPTH];
  logic [7:0]               a_q, b_q;
  job_t                     cur;
  logic [SLOT_W-1:0]        rs0, rs, wk, wj;
  logic                     iss_done, rd_vld, rd_last, issue, last_pos, we;
  logic signed [DISP_W-1:0] d, best_d;
  logic [SUM_W-1:0]         s1, s2;
  logic [SQ_W-1:0]          s11, s22, s12;
  logic [31:0]              ma, mb, mc, md, va, vb, abs_cov;
  logic signed [32:0]       cov;
  logic [63:0]              sq_v, sq_r, sq_bit, sq_t;
  logic                     sq_ge, div_ge;
  logic [5:0]               cnt;
  logic [47:0]              num, quo;
  logic [32:0]              rem, rem_s;
  logic [16:0]              neg17;
  logic signed [15:0]       score, best, sat;
  logic                     tested;
  logic [COL_W-1:0]         lcol, rcol;
  logic signed [13:0]       rcol_s;
  logic [AW-1:0]            raddr_l, raddr_r, waddr;

  assign job_ready = (state == S_IDLE);
  assign we        = (state == S_IDLE) && job_valid;
  assign issue     = ((state == S_SUMA) || (state == S_CORR)) && !iss_done;
  assign last_pos  = (wk == SLOT_W'(ROWS - 1)) && (wj == SLOT_W'(ROWS - 1));

  always_comb begin
    lcol    = cur.col - COL_W'(2 * WIN) + COL_W'(wj);
    rcol_s  = $signed({2'b0, cur.col}) - 14'sd0 - 14'(2 * WIN) + 14'(d)
              + $signed({10'b0, wj});
    rcol    = rcol_s[COL_W-1:0];
    raddr_l = AW'(int'(rs) * MAX_WIDTH + int'(lcol));
    raddr_r = AW'(int'(rs) * MAX_WIDTH + int'(rcol));
    waddr   = AW'(int'(job.slot) * MAX_WIDTH + int'(job.col));
    sq_t    = sq_r + sq_bit;
    sq_ge   = (sq_v >= sq_t);
    rem_s   = {rem[31:0], num[47]};
    div_ge  = (rem_s >= {1'b0, sq_r[31:0]});
    abs_cov = cov[32] ? 32'(-cov) : cov[31:0];
    neg17   = 17'd0 - {1'b0, quo[15:0]};
    if (cov[32]) begin
      sat = (quo > 48'd32768) ? -16'sd32768 : $signed(neg17[15:0]);
    end else begin
      sat = (quo > 48'd32767) ? 16'sd32767 : $signed(quo[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lmem[waddr] <= job.left_pixel;
      rmem[waddr] <= job.right_pixel;
    end
    a_q <= lmem[raddr_l];
    b_q <= rmem[raddr_r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      rd_vld       <= 1'b0;
      rd_last      <= 1'b0;
      iss_done     <= 1'b0;
    end else begin
      rd_vld  <= issue;
      rd_last <= issue && last_pos;
      if (issue) begin
        if (last_pos) iss_done <= 1'b1;
        if (wj == SLOT_W'(ROWS - 1)) begin
          wj <= '0;
          wk <= wk + SLOT_W'(1);
          rs <= (rs == SLOT_W'(ROWS - 1)) ? '0 : rs + SLOT_W'(1);
        end else begin
          wj <= wj + SLOT_W'(1);
        end
      end
      if (result_valid && result_ready) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur      <= job;
            rs0      <= (job.slot == SLOT_W'(ROWS - 1)) ? '0 : job.slot + SLOT_W'(1);
            rs       <= (job.slot == SLOT_W'(ROWS - 1)) ? '0 : job.slot + SLOT_W'(1);
            wk       <= '0;
            wj       <= '0;
            iss_done <= 1'b0;
            s1       <= '0;
            s11      <= '0;
            d        <= job.d_lo;
            best     <= -16'sd32768;
            best_d   <= '0;
            tested   <= 1'b0;
            state    <= job.search ? S_SUMA : S_DONE;
          end
        end
        S_SUMA: begin
          if (rd_vld) begin
            s1  <= s1 + SUM_W'(a_q);
            s11 <= s11 + SQ_W'(a_q * a_q);
            if (rd_last) state <= S_VAM;
          end
        end
        S_VAM: begin
          ma    <= 32'(NPIX) * 32'(s11);
          mb    <= 32'(s1) * 32'(s1);
          state <= S_VAD;
        end
        S_VAD: begin
          va       <= (ma >= mb) ? ma - mb : '0;
          rs       <= rs0;
          wk       <= '0;
          wj       <= '0;
          iss_done <= 1'b0;
          s2       <= '0;
          s22      <= '0;
          s12      <= '0;
          state    <= S_CORR;
        end
        S_CORR: begin
          if (rd_vld) begin
            s2  <= s2 + SUM_W'(b_q);
            s22 <= s22 + SQ_W'(b_q * b_q);
            s12 <= s12 + SQ_W'(a_q * b_q);
            if (rd_last) state <= S_MUL;
          end
        end
        S_MUL: begin
          ma    <= 32'(NPIX) * 32'(s12);
          mb    <= 32'(s1) * 32'(s2);
          mc    <= 32'(NPIX) * 32'(s22);
          md    <= 32'(s2) * 32'(s2);
          state <= S_DIF;
        end
        S_DIF: begin
          cov   <= $signed({1'b0, ma}) - $signed({1'b0, mb});
          vb    <= (mc >= md) ? mc - md : '0;
          state <= S_PROD;
        end
        S_PROD: begin
          sq_v   <= 64'(va) * 64'(vb);
          sq_r   <= '0;
          sq_bit <= 64'd1 << 62;
          cnt    <= '0;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v <= sq_v - sq_t;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd31) state <= S_DIVP;
        end
        S_DIVP: begin
          num <= {1'b0, abs_cov, 15'b0};
          rem <= '0;
          quo <= '0;
          cnt <= '0;
          if (sq_r == 64'd0) begin
            score <= 16'sd0;
            state <= S_NEXT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= div_ge ? rem_s - {1'b0, sq_r[31:0]} : rem_s;
          quo <= {quo[46:0], div_ge};
          num <= num << 1;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd47) state <= S_SCORE;
        end
        S_SCORE: begin
          score <= sat;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (!tested || (score > best)) begin
            best   <= score;
            best_d <= d;
            tested <= 1'b1;
          end
          if (d == cur.d_hi) begin
            state <= S_DONE;
          end else begin
            d     <= d + DISP_W'(1);
            rs    <= rs0;
            wk    <= '0;
            wj    <= '0;
            iss_done <= 1'b0;
            s2    <= '0;
            s22   <= '0;
            s12   <= '0;
            state <= S_CORR;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            valid_res    <= tested && (best > threshold);
            disparity    <= (tested && (best > threshold)) ? best_d : '0;
            match_score  <= best;
            frame_end    <= cur.frame_end;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/ncc_stereo_block_matcher.sv
// ----------------------------------------------------------------------------
// ncc_stereo_block_matcher
// Streaming stereo matcher: zero-mean NCC over a square window, winner take
// all over the disparity range, one result word per pixel word.
// ----------------------------------------------------------------------------
//   channel   signals                                      word
//   pixel     pixel_valid/pixel_ready                      left_pixel, right_pixel
//   result    result_valid/result_ready                    disparity, match_score,
//                                                          valid_res, frame_end
//   cfg       cfg_valid/cfg_ready                          cfg_index, cfg_data
//
// A pixel outside the border or with an empty range skips the search.
// Otherwise the left window sums come first, and then each candidate
// disparity in turn passes through its window sums and the shared
// bit-serial square root and divider. Reset is synchronous and needs no
// clearing pass. A two-entry queue and the result register let the front
// and back stall independently.
// ----------------------------------------------------------------------------
module ncc_stereo_block_matcher #(
  parameter int WIN       = 4,
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_DISP  = 63
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_ready,
  input  logic [7:0]                           left_pixel,
  input  logic [7:0]                           right_pixel,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nccsbm_pkg::IDX_W-1:0]         cfg_index,
  input  logic [15:0]                          cfg_data,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [nccsbm_pkg::DISP_W-1:0] disparity,
  output logic signed [15:0]                   match_score,
  output logic                                 valid_res,
  output logic                                 frame_end
);
  import nccsbm_pkg::*;

  job_t               f_job, q_job;
  logic               f_valid, f_ready, q_valid, q_ready;
  logic signed [15:0] threshold;

  nccsbm_front #(.WIN(WIN), .MAX_WIDTH(MAX_WIDTH), .MAX_DISP(MAX_DISP)) u_front (
    .clk, .rst, .pixel_valid, .pixel_ready, .left_pixel, .right_pixel,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job), .threshold
  );

  nccsbm_queue u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_job),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_job)
  );

  nccsbm_back #(.WIN(WIN), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk, .rst, .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .threshold, .result_valid, .result_ready, .disparity, .match_score,
    .valid_res, .frame_end
  );

endmodule

### hw/rtl/nccsbm_checker.sv
// ----------------------------------------------------------------------------
// nccsbm_checker
// Port-level checks of the stereo matcher, bound to the top level.
// ----------------------------------------------------------------------------
module nccsbm_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 result_valid,
  input logic                                 result_ready,
  input logic signed [nccsbm_pkg::DISP_W-1:0] disparity,
  input logic signed [15:0]                   match_score,
  input logic                                 valid_res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(match_score))
    else $error("result word dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !valid_res |-> disparity == '0)
    else $error("disparity not zero on an invalid result");

  a_valid_score: assert property (@(posedge clk) disable iff (rst)
    result_valid && valid_res |-> disparity <= 0 && match_score != -16'sd32768)
    else $error("valid result without a tested disparity");

endmodule

bind ncc_stereo_block_matcher nccsbm_checker u_checker (.*);
